/* sv/bclk_pkg.sv */
`default_nettype none

package bclk_pkg;

    // Wrap limits of the clock counters.
    localparam logic [5:0] SEC_LIMIT  = 6'd60;
    localparam logic [5:0] MIN_LIMIT  = 6'd60;
    localparam logic [5:0] HOUR_LIMIT = 6'd12;

    // Reset values of the configuration registers.
    localparam logic [5:0] WAKE_RESET        = 6'd30;
    localparam logic [5:0] MINUTE_WAKE_RESET = 6'd3;

    // Register indexes on the configuration port.
    localparam logic REG_WAKE        = 1'b0;
    localparam logic REG_MINUTE_WAKE = 1'b1;

    // Encodings of the mode as reported on the result.
    localparam logic [1:0] MODE_CODE_RUN      = 2'd0;
    localparam logic [1:0] MODE_CODE_SET_HOUR = 2'd1;
    localparam logic [1:0] MODE_CODE_SET_MIN  = 2'd2;

    // Fixed second LED patterns of the set modes.
    localparam logic [1:0] SEC_PAT_SET_HOUR = 2'b01;
    localparam logic [1:0] SEC_PAT_SET_MIN  = 2'b10;

    typedef enum logic [2:0] {
        MODE_RUN      = 3'b001,
        MODE_SET_HOUR = 3'b010,
        MODE_SET_MIN  = 3'b100
    } t_mode;

    typedef struct packed {
        logic menu_button;
        logic up_button;
        logic down_button;
    } t_in_req;

    typedef struct packed {
        logic [1:0] second_leds;
        logic [5:0] minute_leds;
        logic [3:0] hour_leds;
        logic [1:0] mode_now;
    } t_out_req;

    typedef struct packed {
        logic [5:0] second_count;
        logic [5:0] minute_count;
        logic [3:0] hour_count;
        logic [5:0] awake_countdown;
        t_mode      clock_mode;
    } t_clk_state;

    // Step a value up and/or down with wrap inside 0..limit-1.
    // A value already out of range snaps to zero.
    function automatic logic [5:0] step_wrap(
        input logic [5:0] v,
        input logic [5:0] limit,
        input logic       up,
        input logic       down
    );
        logic [5:0] r;
        r = v;
        if (v >= limit) begin
            r = 6'd0;
        end else begin
            if (up) begin
                r = (r == limit - 6'd1) ? 6'd0 : r + 6'd1;
            end
            if (down) begin
                r = (r == 6'd0) ? limit - 6'd1 : r - 6'd1;
            end
        end
        return r;
    endfunction

    // Run-mode second pattern: parity in bit 0, its inverse in bit 1.
    function automatic logic [1:0] run_pattern(input logic parity);
        return {~parity, parity};
    endfunction

endpackage

`default_nettype wire

/* sv/bclk_step.sv */
`default_nettype none

module bclk_step (
    input  var bclk_pkg::t_clk_state i_state,
    input  var bclk_pkg::t_in_req    i_req,
    input  wire logic [5:0]          i_wake_seconds,
    input  wire logic [5:0]          i_minute_wake_seconds,
    output var bclk_pkg::t_clk_state o_state,
    output var bclk_pkg::t_out_req   o_rsp
);
    import bclk_pkg::*;

    logic       menu;
    logic       up;
    logic       down;
    logic [5:0] cd_btn;
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [4:0] hour_inc;
    logic [5:0] cd_dec;
    logic       was_on;

    always_comb begin
        menu = i_req.menu_button;
        up   = i_req.up_button;
        down = i_req.down_button;

        o_state = i_state;
        o_rsp   = '0;

        // Run-mode intermediate values.
        cd_btn   = (up || down) ? i_wake_seconds : i_state.awake_countdown;
        was_on   = (cd_btn != 6'd0);
        cd_dec   = was_on ? cd_btn - 6'd1 : 6'd0;
        sec_inc  = {1'b0, i_state.second_count} + 7'd1;
        min_inc  = {1'b0, i_state.minute_count} + 7'd1;
        hour_inc = {1'b0, i_state.hour_count} + 5'd1;

        case (i_state.clock_mode)
            MODE_SET_HOUR: begin
                o_state.hour_count = 4'(step_wrap({2'b00, i_state.hour_count},
                                                  HOUR_LIMIT, up, down));
                if (menu) begin
                    o_state.clock_mode = MODE_SET_MIN;
                    o_rsp.second_leds  = SEC_PAT_SET_MIN;
                    o_rsp.mode_now     = MODE_CODE_SET_MIN;
                end else begin
                    o_rsp.second_leds  = SEC_PAT_SET_HOUR;
                    o_rsp.mode_now     = MODE_CODE_SET_HOUR;
                end
                o_rsp.minute_leds = o_state.minute_count;
                o_rsp.hour_leds   = o_state.hour_count;
            end
            MODE_SET_MIN: begin
                o_state.minute_count = step_wrap(i_state.minute_count,
                                                 MIN_LIMIT, up, down);
                if (menu) begin
                    // Back to run: reload the countdown and show the run view.
                    o_state.clock_mode      = MODE_RUN;
                    o_state.awake_countdown = i_wake_seconds;
                    o_rsp.mode_now          = MODE_CODE_RUN;
                    if (i_wake_seconds != 6'd0) begin
                        o_rsp.second_leds = run_pattern(i_state.second_count[0]);
                        o_rsp.minute_leds = o_state.minute_count;
                        o_rsp.hour_leds   = o_state.hour_count;
                    end
                end else begin
                    o_rsp.second_leds = SEC_PAT_SET_MIN;
                    o_rsp.minute_leds = o_state.minute_count;
                    o_rsp.hour_leds   = o_state.hour_count;
                    o_rsp.mode_now    = MODE_CODE_SET_MIN;
                end
            end
            default: begin
                // Run mode; an unknown mode code behaves the same way.
                o_state.clock_mode      = MODE_RUN;
                o_state.awake_countdown = cd_btn;
                if (menu) begin
                    o_state.clock_mode = MODE_SET_HOUR;
                    o_rsp.second_leds  = SEC_PAT_SET_HOUR;
                    o_rsp.minute_leds  = i_state.minute_count;
                    o_rsp.hour_leds    = i_state.hour_count;
                    o_rsp.mode_now     = MODE_CODE_SET_HOUR;
                end else begin
                    // One second tick.
                    o_state.awake_countdown = cd_dec;
                    o_state.second_count    = sec_inc[5:0];
                    if (sec_inc >= {1'b0, SEC_LIMIT}) begin
                        if (cd_dec == 6'd0) begin
                            o_state.awake_countdown = i_minute_wake_seconds;
                        end
                        o_state.second_count = 6'd0;
                        o_state.minute_count = min_inc[5:0];
                        if (min_inc >= {1'b0, MIN_LIMIT}) begin
                            o_state.minute_count = 6'd0;
                            o_state.hour_count =
                                (hour_inc >= {1'b0, HOUR_LIMIT[3:0]})
                                ? 4'(hour_inc - {1'b0, HOUR_LIMIT[3:0]})
                                : hour_inc[3:0];
                        end
                    end
                    if (was_on) begin
                        o_rsp.second_leds = run_pattern(i_state.second_count[0]);
                    end
                    if (o_state.awake_countdown != 6'd0) begin
                        o_rsp.minute_leds = o_state.minute_count;
                        o_rsp.hour_leds   = o_state.hour_count;
                    end
                    o_rsp.mode_now = MODE_CODE_RUN;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/binary_led_clock_with_set_mode_core.sv */
// A request accepted at a clock edge has its result registered on o_out_data at that edge.
// Throughput: one request per cycle; the state update and result are one pass of logic.
// A result waiting in the output register blocks new requests only while i_ready is low;
// a request is taken in the same cycle in which the waiting result leaves.
// Reset (i_rst_n low, synchronous): time zero, run mode, countdown 30, registers 30 and 3.
`default_nettype none

module binary_led_clock_with_set_mode_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Button request channel.
    input  wire logic                i_valid,
    output var  logic                o_ready,
    input  var  bclk_pkg::t_in_req   i_in_data,
    // Result channel.
    output var  logic                o_valid,
    input  wire logic                i_ready,
    output var  bclk_pkg::t_out_req  o_out_data,
    // Configuration port.
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output var  logic [31:0]         prdata,
    output var  logic                pready
);
    import bclk_pkg::*;

    // Clock state: seconds, minutes, hours, screen countdown and mode.
    t_clk_state r_state;
    t_clk_state n_state;

    // Configuration registers.
    logic [5:0] r_wake_seconds;
    logic [5:0] r_minute_wake_seconds;

    // Output register. The request side keeps moving as long as the result
    // register is empty or is being emptied in the same cycle.
    t_out_req r_out;
    t_out_req n_out;
    logic     r_out_valid;

    logic accept;
    logic cfg_write;

    assign o_ready    = !r_out_valid || i_ready;
    assign accept     = i_valid && o_ready;
    assign o_valid    = r_out_valid;
    assign o_out_data = r_out;

    // The APB-style port never stalls; a write lands in the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_WAKE:        prdata = {26'd0, r_wake_seconds};
            REG_MINUTE_WAKE: prdata = {26'd0, r_minute_wake_seconds};
            default:         prdata = 32'd0;
        endcase
    end

    // Next state and result of the request at the input.
    bclk_step u_step (
        .i_state               (r_state),
        .i_req                 (i_in_data),
        .i_wake_seconds        (r_wake_seconds),
        .i_minute_wake_seconds (r_minute_wake_seconds),
        .o_state               (n_state),
        .o_rsp                 (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.second_count    <= 6'd0;
            r_state.minute_count    <= 6'd0;
            r_state.hour_count      <= 4'd0;
            r_state.awake_countdown <= WAKE_RESET;
            r_state.clock_mode      <= MODE_RUN;
            r_wake_seconds          <= WAKE_RESET;
            r_minute_wake_seconds   <= MINUTE_WAKE_RESET;
            r_out_valid             <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_write) begin
                case (paddr[2])
                    REG_WAKE:        r_wake_seconds        <= pwdata[5:0];
                    REG_MINUTE_WAKE: r_minute_wake_seconds <= pwdata[5:0];
                    default:         r_wake_seconds        <= r_wake_seconds;
                endcase
            end
        end
    end

    // Result payload, loaded with each accepted request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

/* sv/bclk_checker.sv */
`default_nettype none

module bclk_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               o_ready,
    input  wire logic               o_valid,
    input  wire logic               i_ready,
    input  var  bclk_pkg::t_out_req o_out_data
);
    import bclk_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // The set-hour mode shows its fixed second pattern, and a result never
    // shows an hour or minute out of range.
    a_set_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_data.mode_now == MODE_CODE_SET_HOUR
        |-> o_out_data.second_leds == SEC_PAT_SET_HOUR)
        else $error("set-hour pattern wrong");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_data.hour_leds < 4'd12 && o_out_data.minute_leds < 6'd60
                    && o_out_data.mode_now != 2'd3)
        else $error("time or mode out of range");

    // A result is always in hand while the request side is blocked.
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("request side blocked without a stalled result");

endmodule

bind binary_led_clock_with_set_mode_core bclk_checker u_bclk_checker (.*);

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench;

    import bclk_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and the signals around the block.
    // ------------------------------------------------------------------
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        i_valid   = 1'b0;
    logic        o_ready;
    t_in_req     i_in_data = '0;

    logic        o_valid;
    logic        i_ready    = 1'b0;
    t_out_req    o_out_data;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    binary_led_clock_with_set_mode_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_data  (i_in_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------
    // Watch model. These mirror the block's state and registers and are
    // advanced once per accepted button request.
    // ------------------------------------------------------------------
    logic [5:0] m_sec;
    logic [5:0] m_min;
    logic [3:0] m_hour;
    logic [5:0] m_awake;
    logic [1:0] m_mode;
    logic [5:0] cfg_wake;
    logic [5:0] cfg_min_wake;

    // LED patterns still owed by the block, oldest first.
    t_out_req   pending_leds [$];

    int         fail_count = 0;

    // Up adds one, down takes one away, both with wrap inside 0..limit-1.
    // A value that is already out of range lands on zero.
    function automatic int wrap_step(int v, int limit, logic up, logic down);
        if (v >= limit) begin
            return 0;
        end
        if (up) begin
            v = (v + 1) % limit;
        end
        if (down) begin
            v = (v + limit - 1) % limit;
        end
        return v;
    endfunction

    // Applies one poll of the buttons to the model and returns the LED
    // pattern the block must show for it.
    function automatic t_out_req advance_watch(t_in_req b);
        t_out_req r;
        logic     parity;
        logic     lit;
        r = '0;
        if (m_mode == MODE_CODE_SET_HOUR) begin
            m_hour = 4'(wrap_step(int'(m_hour), int'(HOUR_LIMIT), b.up_button, b.down_button));
            if (b.menu_button) begin
                m_mode = MODE_CODE_SET_MIN;
            end
        end else if (m_mode == MODE_CODE_SET_MIN) begin
            m_min = 6'(wrap_step(int'(m_min), int'(MIN_LIMIT), b.up_button, b.down_button));
            if (b.menu_button) begin
                m_mode  = MODE_CODE_RUN;
                m_awake = cfg_wake;
            end
        end else begin
            m_mode = MODE_CODE_RUN;
            if (b.up_button || b.down_button) begin
                m_awake = cfg_wake;
            end
            if (b.menu_button) begin
                m_mode = MODE_CODE_SET_HOUR;
            end else begin
                // One second tick. The seconds LEDs show the parity from
                // before the tick and go dark by the countdown before it;
                // the time LEDs go dark by the countdown after it.
                parity = m_sec[0];
                lit    = (m_awake != 6'd0);
                m_sec  = m_sec + 6'd1;
                if (m_awake != 6'd0) begin
                    m_awake = m_awake - 6'd1;
                end
                if (m_sec >= SEC_LIMIT) begin
                    if (m_awake == 6'd0) begin
                        m_awake = cfg_min_wake;
                    end
                    m_sec = 6'd0;
                    m_min = m_min + 6'd1;
                    if (m_min >= MIN_LIMIT) begin
                        m_hour = 4'((int'(m_hour) + 1) % int'(HOUR_LIMIT));
                        m_min  = 6'd0;
                    end
                end
                r.second_leds = lit ? {~parity, parity} : 2'b00;
                r.minute_leds = (m_awake != 6'd0) ? m_min : 6'd0;
                r.hour_leds   = (m_awake != 6'd0) ? m_hour : 4'd0;
                r.mode_now    = MODE_CODE_RUN;
                return r;
            end
        end

        // Results without a tick: the set modes are never dark, and the
        // run mode is dark by the current countdown.
        if (m_mode == MODE_CODE_SET_HOUR) begin
            r.second_leds = SEC_PAT_SET_HOUR;
            r.minute_leds = m_min;
            r.hour_leds   = m_hour;
        end else if (m_mode == MODE_CODE_SET_MIN) begin
            r.second_leds = SEC_PAT_SET_MIN;
            r.minute_leds = m_min;
            r.hour_leds   = m_hour;
        end else begin
            lit           = (m_awake != 6'd0);
            r.second_leds = lit ? {~m_sec[0], m_sec[0]} : 2'b00;
            r.minute_leds = lit ? m_min : 6'd0;
            r.hour_leds   = lit ? m_hour : 4'd0;
        end
        r.mode_now = m_mode;
        return r;
    endfunction

    function automatic void note_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed requests. Rows whose pattern is plain from the reset state
    // carry it here; the others take the model's pattern. They walk the
    // hour wrap at both ends, the minute wrap at both ends, up and down
    // together, menu pressed with other buttons, and entry to and exit
    // from both set modes.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic     known;
        t_in_req  btn;
        t_out_req want;
    } t_directed_row;

    localparam int N_DIRECTED = 24;

    localparam t_directed_row DIRECTED [N_DIRECTED] = '{
        '{1'b1, 3'b000, {2'b10, 6'd0,  4'd0,  MODE_CODE_RUN}},
        '{1'b1, 3'b000, {2'b01, 6'd0,  4'd0,  MODE_CODE_RUN}},
        '{1'b0, 3'b010, 14'd0},
        '{1'b0, 3'b011, 14'd0},
        '{1'b1, 3'b100, {2'b01, 6'd0,  4'd0,  MODE_CODE_SET_HOUR}},
        '{1'b1, 3'b001, {2'b01, 6'd0,  4'd11, MODE_CODE_SET_HOUR}},
        '{1'b1, 3'b010, {2'b01, 6'd0,  4'd0,  MODE_CODE_SET_HOUR}},
        '{1'b1, 3'b011, {2'b01, 6'd0,  4'd0,  MODE_CODE_SET_HOUR}},
        '{1'b1, 3'b001, {2'b01, 6'd0,  4'd11, MODE_CODE_SET_HOUR}},
        '{1'b1, 3'b111, {2'b10, 6'd0,  4'd11, MODE_CODE_SET_MIN}},
        '{1'b1, 3'b001, {2'b10, 6'd59, 4'd11, MODE_CODE_SET_MIN}},
        '{1'b1, 3'b010, {2'b10, 6'd0,  4'd11, MODE_CODE_SET_MIN}},
        '{1'b1, 3'b001, {2'b10, 6'd59, 4'd11, MODE_CODE_SET_MIN}},
        '{1'b1, 3'b011, {2'b10, 6'd59, 4'd11, MODE_CODE_SET_MIN}},
        '{1'b1, 3'b100, {2'b10, 6'd59, 4'd11, MODE_CODE_RUN}},
        '{1'b0, 3'b000, 14'd0},
        '{1'b0, 3'b101, 14'd0},
        '{1'b0, 3'b110, 14'd0},
        '{1'b0, 3'b101, 14'd0},
        '{1'b0, 3'b000, 14'd0},
        '{1'b0, 3'b111, 14'd0},
        '{1'b0, 3'b100, 14'd0},
        '{1'b0, 3'b100, 14'd0},
        '{1'b0, 3'b000, 14'd0}
    };

    // ------------------------------------------------------------------
    // Random button sequences. Most of them are well formed: long runs of
    // plain ticks with the odd wake press, then a visit to the set modes
    // that steers the hour and the minute toward a goal (often the ends of
    // their ranges, so that the hour rolls over soon after). A few polls
    // are pure noise.
    // ------------------------------------------------------------------
    int run_left    = 40;
    int set_budget  = 0;
    int hour_goal   = 0;
    int minute_goal = 0;

    function automatic t_in_req steer(int cur, int goal, int limit);
        t_in_req b;
        int      ahead;
        b = '0;
        if ($urandom_range(0, 99) < 15) begin
            b.up_button   = 1'($urandom_range(0, 1));
            b.down_button = 1'($urandom_range(0, 1));
        end else begin
            ahead = (goal - cur + limit) % limit;
            if (ahead <= limit / 2) begin
                b.up_button = 1'b1;
            end else begin
                b.down_button = 1'b1;
            end
        end
        return b;
    endfunction

    function automatic t_in_req choose_buttons();
        t_in_req b;
        int      roll;
        b    = '0;
        roll = $urandom_range(0, 199);
        if (roll < 10) begin
            b = t_in_req'(3'($urandom_range(0, 7)));
        end else if (m_mode == MODE_CODE_SET_HOUR) begin
            if (set_budget == 0 || int'(m_hour) == hour_goal) begin
                b.menu_button = 1'b1;
                if ($urandom_range(0, 4) == 0) begin
                    b.up_button   = 1'($urandom_range(0, 1));
                    b.down_button = 1'($urandom_range(0, 1));
                end
                roll        = $urandom_range(0, 99);
                minute_goal = (roll < 40) ? 59 : (roll < 55) ? 0 : $urandom_range(0, 59);
                set_budget  = $urandom_range(4, 40);
            end else begin
                set_budget--;
                b = steer(int'(m_hour), hour_goal, int'(HOUR_LIMIT));
            end
        end else if (m_mode == MODE_CODE_SET_MIN) begin
            if (set_budget == 0 || int'(m_min) == minute_goal) begin
                b.menu_button = 1'b1;
                if ($urandom_range(0, 4) == 0) begin
                    b.up_button   = 1'($urandom_range(0, 1));
                    b.down_button = 1'($urandom_range(0, 1));
                end
                run_left = ($urandom_range(0, 9) < 7) ? $urandom_range(60, 200)
                                                      : $urandom_range(2, 40);
            end else begin
                set_budget--;
                b = steer(int'(m_min), minute_goal, int'(MIN_LIMIT));
            end
        end else if (run_left > 0) begin
            run_left--;
            roll = $urandom_range(0, 199);
            if (roll < 2) begin
                b.up_button = 1'b1;
            end else if (roll < 4) begin
                b.down_button = 1'b1;
            end else if (roll < 5) begin
                b.up_button   = 1'b1;
                b.down_button = 1'b1;
            end
        end else begin
            b.menu_button = 1'b1;
            roll       = $urandom_range(0, 99);
            hour_goal  = (roll < 30) ? 11 : (roll < 50) ? 0 : $urandom_range(0, 11);
            set_budget = $urandom_range(4, 30);
        end
        return b;
    endfunction

    // Pause lengths for both sides: mostly none or short, a few long, and
    // now and then a calm stretch with no pauses at all.
    function automatic int pick_pause(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 99) < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Request and result handling. Everything is sampled and driven at the
    // rising edge in this one process, so the result check always sees the
    // queue as it stood before this edge's request was added.
    // ------------------------------------------------------------------
    int send_limit = 0;   // requests allowed so far; raised phase by phase
    int issued     = 0;
    int accepted   = 0;
    int gap_left   = 0;
    int stall_left = 0;
    int calm_in    = 0;
    int calm_out   = 0;
    int cur_row    = -1;

    always @(posedge i_clk) begin : traffic
        t_out_req predicted;
        t_out_req want;
        logic     holding;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_ready    <= 1'b0;
            i_in_data  <= '0;
            m_sec      = '0;
            m_min      = '0;
            m_hour     = '0;
            m_awake    = WAKE_RESET;
            m_mode     = MODE_CODE_RUN;
            gap_left   = 0;
            stall_left = 0;
            cur_row    = -1;
        end else begin
            // Result side: compare against the oldest pattern still owed.
            if (o_valid && i_ready) begin
                if (pending_leds.size() == 0) begin
                    $error("result with no request outstanding: %h", o_out_data);
                    fail_count++;
                end else begin
                    want = pending_leds.pop_front();
                    note_field("second_leds", want.second_leds, o_out_data.second_leds);
                    note_field("minute_leds", want.minute_leds, o_out_data.minute_leds);
                    note_field("hour_leds",   want.hour_leds,   o_out_data.hour_leds);
                    note_field("mode_now",    want.mode_now,    o_out_data.mode_now);
                end
                stall_left = pick_pause(calm_out);
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
            end

            // Request side: the model moves on only when the block takes
            // the request, so the next choice sees the up-to-date state.
            holding = i_valid;
            if (i_valid && o_ready) begin
                predicted = advance_watch(i_in_data);
                if (cur_row >= 0 && DIRECTED[cur_row].known) begin
                    pending_leds.push_back(DIRECTED[cur_row].want);
                end else begin
                    pending_leds.push_back(predicted);
                end
                accepted++;
                holding  = 1'b0;
                gap_left = pick_pause(calm_in);
            end
            if (!holding) begin
                if (gap_left > 0 || issued >= send_limit) begin
                    i_valid <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                end else begin
                    i_valid <= 1'b1;
                    if (issued < N_DIRECTED) begin
                        cur_row   = issued;
                        i_in_data <= DIRECTED[issued].btn;
                    end else begin
                        cur_row   = -1;
                        i_in_data <= choose_buttons();
                    end
                    issued++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Register access. A write is a setup phase then an access phase; the
    // register takes the value at the edge that closes the access phase.
    // ------------------------------------------------------------------
    task automatic write_register(input logic idx, input logic [5:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {26'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WAKE) begin
            cfg_wake = value;
        end else begin
            cfg_min_wake = value;
        end
    endtask

    // Reads a register back; prdata is taken at the edge ending the access.
    task automatic check_register(input logic idx, input logic [5:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        note_field((idx == REG_WAKE) ? "wake_seconds" : "minute_wake_seconds",
                   {26'd0, want}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Run control. Six phases, each with its own register setting: the
    // reset values, both registers at one, both at their maximum,
    // the two mixed extremes, and a random pair. Registers only change once
    // every result of the previous phase has come back.
    // ------------------------------------------------------------------
    initial begin : run_control
        int         phase;
        logic [5:0] wake_val;
        logic [5:0] min_wake_val;
        cfg_wake     = WAKE_RESET;
        cfg_min_wake = MINUTE_WAKE_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    wake_val     = WAKE_RESET;
                    min_wake_val = MINUTE_WAKE_RESET;
                end
                1: begin
                    wake_val     = 6'd1;
                    min_wake_val = 6'd1;
                end
                2: begin
                    wake_val     = 6'd63;
                    min_wake_val = 6'd63;
                end
                3: begin
                    wake_val     = 6'd1;
                    min_wake_val = 6'd63;
                end
                4: begin
                    wake_val     = 6'd63;
                    min_wake_val = 6'd1;
                end
                default: begin
                    wake_val     = 6'($urandom_range(1, 63));
                    min_wake_val = 6'($urandom_range(1, 63));
                end
            endcase
            if (phase > 0) begin
                write_register(REG_WAKE, wake_val);
                write_register(REG_MINUTE_WAKE, min_wake_val);
            end
            check_register(REG_WAKE, wake_val);
            check_register(REG_MINUTE_WAKE, min_wake_val);

            send_limit = send_limit + ((phase == 0) ? N_DIRECTED : 0) + 310;
            while (accepted < send_limit || pending_leds.size() != 0) begin
                @(posedge i_clk);
            end
            // The block registers each result as it takes the request; spare
            // cycles let a stray extra result show up before moving on.
            repeat (4) @(posedge i_clk);
        end

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, even with every pause at
    // its longest on both sides.
    initial begin : watchdog
        #10000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
